[rtl/murmur3_x64_128_hasher_assert.svh]
// Assertion macros shared by the hasher RTL.
`ifndef MURMUR3_X64_128_HASHER_ASSERT_SVH
`define MURMUR3_X64_128_HASHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/mm3h_pkg.sv]
package mm3h_pkg;

	// Key length counter width; the count saturates at 2^(LENGTH_BITS-1)
	localparam int LENGTH_BITS = 32;
	localparam logic [LENGTH_BITS-1:0] LEN_SAT = LENGTH_BITS'(1) << (LENGTH_BITS - 1);

	// Block scramble and finalizer constants
	localparam logic [63:0] MIX_C1  = 64'h87c37b91114253d5;
	localparam logic [63:0] MIX_C2  = 64'h4cf5ad432745937f;
	localparam logic [63:0] ADD_ONE = 64'h0000000052dce729;
	localparam logic [63:0] ADD_TWO = 64'h0000000038495ab5;
	localparam logic [63:0] FIN_C1  = 64'hff51afd7ed558ccd;
	localparam logic [63:0] FIN_C2  = 64'hc4ceb9fe1a85ec53;

	// Rotate left by a fixed amount between 1 and 63
	function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
		rotl64 = (x << r) | (x >> (64 - r));
	endfunction

endpackage

[rtl/murmur3_x64_128_hasher.sv]
// Channel   Dir  Handshake               Payload
// in        in   in_valid / in_ready     data_byte[7:0], byte_valid, last_byte
// out       out  out_valid / out_ready   hash_low[63:0], hash_high[63:0], too_long
// seed cfg  in   seed_valid / seed_ready seed[31:0]
//
// A byte that does not complete a 16-byte block is only buffered; the byte that
// completes a block starts a block mix of both lanes. An item marked last runs
// the tail, the length fold and two finalizers before the result, after a block
// mix first when that same byte also completes a block.
// Every 64-bit product runs through one shared 32x32 multiplier as lo*lo, lo*hi
// and hi*lo partial products. Async active-low reset; seed resets to zero.
// The result sits in an output register, so a new key can start while it waits;
// only the next finish stalls until the previous result is taken.

`include "murmur3_x64_128_hasher_assert.svh"

module murmur3_x64_128_hasher
	import mm3h_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// key byte channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        last_byte,
	// hash result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] hash_low,
	output logic [63:0] hash_high,
	output logic        too_long,
	// seed register write
	input  logic        seed_valid,
	output logic        seed_ready,
	input  logic [31:0] seed
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_MUL,
		S_ROT,
		S_MERGE,
		S_ADDL,
		S_TIMES5,
		S_FLEN,
		S_FADD1,
		S_FADD2,
		S_FLOAD,
		S_FSHIFT,
		S_FSTORE,
		S_FADD3,
		S_FADD4
	} state_t;

	// which multiply of a sequence is running
	typedef enum logic [1:0] {
		PH_SA,
		PH_SB,
		PH_FA,
		PH_FB
	} phase_t;

	state_t                 state_q;
	phase_t                 phase_q;
	logic                   lane_q;
	logic                   tail_q;
	logic                   last_q;
	logic [1:0]             mcnt_q;
	logic [1:0]             fsh_q;
	logic [63:0]            h1_q;
	logic [63:0]            h2_q;
	logic [63:0]            k_q;
	logic [63:0]            acc_q;
	logic [7:0]             buf_q [16];
	logic [3:0]             pos_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic [31:0]            seed_q;
	logic                   out_valid_q;
	logic [63:0]            hash_low_q;
	logic [63:0]            hash_high_q;
	logic                   too_long_q;

	logic [63:0] word0;
	logic [63:0] word1;
	logic [63:0] mul_const;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [63:0] len_ext;
	logic        out_free;

	assign in_ready   = (state_q == S_IDLE);
	assign seed_ready = 1'b1;
	assign out_valid  = out_valid_q;
	assign hash_low   = hash_low_q;
	assign hash_high  = hash_high_q;
	assign too_long   = too_long_q;
	assign len_ext    = 64'(len_q);
	assign out_free   = !out_valid_q || out_ready;

	// block words, little endian; in tail mode bytes past the position read as zero
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			word0[8*i +: 8] = (!tail_q || (4'(i) < pos_q)) ? buf_q[i] : 8'h00;
			word1[8*i +: 8] = (!tail_q || ((5'(i) + 5'd8) < {1'b0, pos_q})) ?
				buf_q[i+8] : 8'h00;
		end
	end

	// multiplier constant by phase and lane
	always_comb begin
		case (phase_q)
			PH_SA:   mul_const = lane_q ? MIX_C2 : MIX_C1;
			PH_SB:   mul_const = lane_q ? MIX_C1 : MIX_C2;
			PH_FA:   mul_const = FIN_C1;
			PH_FB:   mul_const = FIN_C2;
			default: mul_const = FIN_C1;
		endcase
	end

	// shared 32x32 multiplier: lo*lo, then lo*hi and hi*lo into the upper half
	assign mul_a = (mcnt_q == 2'd2) ? k_q[63:32] : k_q[31:0];
	assign mul_b = (mcnt_q == 2'd1) ? mul_const[63:32] : mul_const[31:0];
	assign prod  = 64'(mul_a) * 64'(mul_b);

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_SA;
			lane_q      <= 1'b0;
			tail_q      <= 1'b0;
			last_q      <= 1'b0;
			mcnt_q      <= 2'd0;
			fsh_q       <= 2'd0;
			h1_q        <= 64'd0;
			h2_q        <= 64'd0;
			k_q         <= 64'd0;
			acc_q       <= 64'd0;
			for (int i = 0; i < 16; i++) begin
				buf_q[i] <= 8'h00;
			end
			pos_q       <= 4'd0;
			len_q       <= '0;
			seed_q      <= 32'd0;
			out_valid_q <= 1'b0;
			hash_low_q  <= 64'd0;
			hash_high_q <= 64'd0;
			too_long_q  <= 1'b0;
		end else begin
			if (seed_valid) begin
				seed_q <= seed;
			end
			// the finish state handles the output register itself
			if (out_valid_q && out_ready && state_q != S_FADD4) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						// a new key starts from the seed
						if (len_q == '0) begin
							h1_q <= 64'(seed_q);
							h2_q <= 64'(seed_q);
						end
						if (byte_valid) begin
							buf_q[pos_q] <= data_byte;
							pos_q        <= pos_q + 4'd1;
							if (len_q < LEN_SAT) begin
								len_q <= len_q + LENGTH_BITS'(1);
							end
						end
						if (byte_valid && pos_q == 4'hF) begin
							tail_q  <= 1'b0;
							lane_q  <= 1'b0;
							last_q  <= last_byte;
							state_q <= S_LOAD;
						end else if (last_byte) begin
							tail_q  <= 1'b1;
							lane_q  <= 1'b0;
							state_q <= S_LOAD;
						end
					end
				end

				S_LOAD: begin
					k_q     <= lane_q ? word1 : word0;
					phase_q <= PH_SA;
					mcnt_q  <= 2'd0;
					state_q <= S_MUL;
				end

				S_MUL: begin
					case (mcnt_q)
						2'd0: begin
							acc_q  <= prod;
							mcnt_q <= 2'd1;
						end
						2'd1: begin
							acc_q[63:32] <= acc_q[63:32] + prod[31:0];
							mcnt_q       <= 2'd2;
						end
						default: begin
							k_q    <= {acc_q[63:32] + prod[31:0], acc_q[31:0]};
							mcnt_q <= 2'd0;
							case (phase_q)
								PH_SA:   state_q <= S_ROT;
								PH_SB:   state_q <= S_MERGE;
								default: begin
									fsh_q   <= fsh_q + 2'd1;
									state_q <= S_FSHIFT;
								end
							endcase
						end
					endcase
				end

				S_ROT: begin
					k_q     <= lane_q ? rotl64(k_q, 33) : rotl64(k_q, 31);
					phase_q <= PH_SB;
					state_q <= S_MUL;
				end

				S_MERGE: begin
					if (tail_q) begin
						if (lane_q) begin
							h2_q    <= h2_q ^ k_q;
							state_q <= S_FLEN;
						end else begin
							h1_q    <= h1_q ^ k_q;
							lane_q  <= 1'b1;
							state_q <= S_LOAD;
						end
					end else begin
						if (lane_q) begin
							h2_q <= rotl64(h2_q ^ k_q, 31);
						end else begin
							h1_q <= rotl64(h1_q ^ k_q, 27);
						end
						state_q <= S_ADDL;
					end
				end

				S_ADDL: begin
					if (lane_q) begin
						h2_q <= h2_q + h1_q;
					end else begin
						h1_q <= h1_q + h2_q;
					end
					state_q <= S_TIMES5;
				end

				// h = h*5 + constant
				S_TIMES5: begin
					if (lane_q) begin
						h2_q <= (h2_q << 2) + h2_q + ADD_TWO;
						if (last_q) begin
							tail_q  <= 1'b1;
							lane_q  <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						h1_q    <= (h1_q << 2) + h1_q + ADD_ONE;
						lane_q  <= 1'b1;
						state_q <= S_LOAD;
					end
				end

				S_FLEN: begin
					h1_q    <= h1_q ^ len_ext;
					h2_q    <= h2_q ^ len_ext;
					state_q <= S_FADD1;
				end

				S_FADD1: begin
					h1_q    <= h1_q + h2_q;
					state_q <= S_FADD2;
				end

				S_FADD2: begin
					h2_q    <= h2_q + h1_q;
					lane_q  <= 1'b0;
					fsh_q   <= 2'd0;
					state_q <= S_FLOAD;
				end

				S_FLOAD: begin
					k_q     <= lane_q ? h2_q : h1_q;
					state_q <= S_FSHIFT;
				end

				// xor-shift, then the next finalizer multiply or the store
				S_FSHIFT: begin
					k_q    <= k_q ^ (k_q >> 33);
					mcnt_q <= 2'd0;
					case (fsh_q)
						2'd0: begin
							phase_q <= PH_FA;
							state_q <= S_MUL;
						end
						2'd1: begin
							phase_q <= PH_FB;
							state_q <= S_MUL;
						end
						default: state_q <= S_FSTORE;
					endcase
				end

				S_FSTORE: begin
					fsh_q <= 2'd0;
					if (lane_q) begin
						h2_q    <= k_q;
						state_q <= S_FADD3;
					end else begin
						h1_q    <= k_q;
						lane_q  <= 1'b1;
						state_q <= S_FLOAD;
					end
				end

				S_FADD3: begin
					h1_q    <= h1_q + h2_q;
					state_q <= S_FADD4;
				end

				// hand over the result once the output register is free
				S_FADD4: begin
					if (out_free) begin
						hash_low_q  <= h1_q;
						hash_high_q <= h2_q + h1_q;
						too_long_q  <= (len_q >= LEN_SAT);
						out_valid_q <= 1'b1;
						pos_q       <= 4'd0;
						len_q       <= '0;
						last_q      <= 1'b0;
						state_q     <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	`MH_ASSERT_NEXT(a_finish_waits, clk, arst_n,
		(state_q == S_FADD4 && out_valid_q && !out_ready),
		(state_q == S_FADD4 && out_valid_q), "finish overwrote a pending result")
	`MH_ASSERT_NEXT(a_finish_clears, clk, arst_n,
		(state_q == S_FADD4 && out_free),
		(state_q == S_IDLE && out_valid_q && len_q == '0 && pos_q == 4'd0),
		"key state not cleared after finish")
	`MH_ASSERT_NEXT(a_block_starts, clk, arst_n,
		(in_valid && in_ready && byte_valid && pos_q == 4'hF),
		(state_q == S_LOAD && !tail_q && !lane_q && pos_q == 4'd0),
		"full block did not start a block mix")
	`MH_ASSERT_NOW(a_mul_count, clk, arst_n,
		(state_q != S_MUL), (mcnt_q == 2'd0), "multiply step count left nonzero")
	`MH_ASSERT_NOW(a_len_sat, clk, arst_n,
		1'b1, (len_q <= LEN_SAT), "key length past saturation")

endmodule
